// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scanout RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/bvs_pkg.sv =====
// Shared types and constants of the bitmap scanout block
package bvs_pkg;

	localparam int VIDEO_WORDS = 8192;
	localparam int TABLE_WORDS = 2048;
	localparam int VIDEO_AW    = $clog2(VIDEO_WORDS);
	localparam int TABLE_AW    = $clog2(TABLE_WORDS);

	// default depth of the queue between front and back (power of two, at least 2)
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [VIDEO_AW-1:0] FLIP_OFFSET = VIDEO_AW'(13'h0400);

	typedef enum logic [1:0] {
		MODE_PIXEL = 2'd0,
		MODE_VIDEO = 2'd1,
		MODE_COLOR = 2'd2,
		MODE_STAR  = 2'd3
	} mode_t;

	// one classified item as it travels from front to back
	typedef struct packed {
		mode_t               mode;
		logic [VIDEO_AW-1:0] vid_addr;
		logic [TABLE_AW-1:0] col_addr;
		logic [TABLE_AW-1:0] star_addr;
		logic [7:0]          wdata;
		logic                fetch;
		logic                star_hit;
	} entry_t;

endpackage

// ===== rtl/bitmap_video_scanout_with_stars.sv =====
// Top level of the bitmap scanout block with star field
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   mode address data x_pos y_count end_of_frame
//  out       source     out_valid / out_ready pixel_color
//  cfg       sink       cfg_we                cfg_wdata (flip_enable)
//
// One item per cycle while out_ready is high; a pixel goes through the queue write at its
// transfer edge, memory read and output register before out_valid rises. The single-port
// memories are used once per item, which sets the one-item-per-cycle figure.
// Reset clears queue, shifter, latches, blink count and flip; memories hold no reset.
// The queue lets input keep flowing while the output is stalled, until it fills.
module bitmap_video_scanout_with_stars import bvs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [12:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_count,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  pixel_color
);

	logic   q_ready;
	logic   q_push;
	entry_t push_entry;
	logic   q_pop;
	logic   head_valid;
	entry_t head_entry;
	logic   flip;

	bvs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.address      (address),
		.data         (data),
		.x_pos        (x_pos),
		.y_count      (y_count),
		.end_of_frame (end_of_frame),
		.q_ready      (q_ready),
		.q_push       (q_push),
		.q_entry      (push_entry),
		.flip         (flip)
	);

	bvs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.ready      (q_ready),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	bvs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.flip        (flip),
		.q_valid     (head_valid),
		.q_entry     (head_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_color (pixel_color)
	);

endmodule

// ===== rtl/bvs_front.sv =====
// Front end: accepts items, works out addresses, keeps flip and blink state
module bvs_front import bvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [12:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_count,
	input  logic        end_of_frame,
	input  logic        q_ready,
	output logic        q_push,
	output entry_t      q_entry,
	output logic        flip
);

	logic                flip_q;
	logic [3:0]          blink_q;
	mode_t               kind;
	logic [VIDEO_AW-1:0] vid_rd;
	logic [TABLE_AW-1:0] col_rd;
	logic [TABLE_AW-1:0] star_rd;

	assign in_ready = q_ready;
	assign q_push   = in_valid && q_ready;
	assign flip     = flip_q;
	assign kind     = mode_t'(mode);

	always_comb begin
		vid_rd  = {y_count, x_pos[7:3]};
		if (flip_q) begin
			vid_rd = ~vid_rd + FLIP_OFFSET;
		end
		col_rd  = {flip_q, y_count[7:3], x_pos[7:3]};
		star_rd = {blink_q[3], y_count[7:4], 1'b1, x_pos[7:3]};
	end

	always_comb begin
		q_entry          = '0;
		q_entry.mode     = kind;
		q_entry.wdata    = data;
		q_entry.fetch    = (x_pos[2:0] == 3'd0);
		q_entry.star_hit = ((x_pos[3:0] & y_count[3:0]) == 4'hf);
		q_entry.vid_addr  = (kind == MODE_VIDEO) ? address : vid_rd;
		q_entry.col_addr  = (kind == MODE_COLOR) ? address[TABLE_AW-1:0] : col_rd;
		q_entry.star_addr = (kind == MODE_STAR) ? address[TABLE_AW-1:0] : star_rd;
	end

	// blink advances at transfer time so later addresses see the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q  <= 1'b0;
			blink_q <= 4'd0;
		end else begin
			if (cfg_we) begin
				flip_q <= cfg_wdata;
			end
			if (q_push && kind == MODE_PIXEL && end_of_frame) begin
				blink_q <= blink_q + 4'd1;
			end
		end
	end

endmodule

// ===== rtl/bvs_queue.sv =====
// Short in-order queue between the front and back parts
`include "assert_macros.svh"
module bvs_queue import bvs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   ready,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign ready      = (cnt_q != CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_CLK(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")
	`ASSERT_CLK(a_pop_nonempty, pop |-> cnt_q != '0, "pop from empty queue")
	`ASSERT_CLK(a_push_room, push |-> cnt_q != CNT_W'(DEPTH), "push into full queue")

endmodule

// ===== rtl/bvs_back.sv =====
// Back end: memories, pixel shifter, colour latches and output register
`include "assert_macros.svh"
module bvs_back import bvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       flip,
	input  logic       q_valid,
	input  entry_t     q_entry,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] pixel_color
);

	logic [7:0] video_mem [VIDEO_WORDS];
	logic [2:0] color_mem [TABLE_WORDS];
	logic [2:0] star_mem  [TABLE_WORDS];

	logic [7:0] vid_rd_q;
	logic [2:0] col_rd_q;
	logic [2:0] star_rd_q;

	logic       valid_s1;
	logic       fetch_s1;
	logic       star_hit_s1;

	logic [7:0] shifter_q;
	logic [2:0] fore_q;
	logic [2:0] star_q;
	logic       out_valid_q;
	logic [2:0] pixel_color_q;

	logic       adv;
	logic       rd_en;
	logic [7:0] sh;
	logic [7:0] sh_next;
	logic [2:0] fore;
	logic [2:0] star;
	logic       pix_bit;
	logic [2:0] color;

	// whole back pipeline moves together; read data holds while stalled
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && q_valid;
	assign rd_en = q_pop && q_entry.mode == MODE_PIXEL && q_entry.fetch;

	assign out_valid   = out_valid_q;
	assign pixel_color = pixel_color_q;

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.mode == MODE_VIDEO) begin
			video_mem[q_entry.vid_addr] <= q_entry.wdata;
		end
		if (q_pop && q_entry.mode == MODE_COLOR) begin
			color_mem[q_entry.col_addr] <= q_entry.wdata[2:0];
		end
		if (q_pop && q_entry.mode == MODE_STAR) begin
			star_mem[q_entry.star_addr] <= q_entry.wdata[2:0];
		end
		if (rd_en) begin
			vid_rd_q  <= video_mem[q_entry.vid_addr];
			col_rd_q  <= color_mem[q_entry.col_addr];
			star_rd_q <= star_mem[q_entry.star_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fetch_s1    <= q_entry.fetch;
			star_hit_s1 <= q_entry.star_hit;
		end
	end

	always_comb begin
		sh      = fetch_s1 ? vid_rd_q : shifter_q;
		fore    = fetch_s1 ? col_rd_q : fore_q;
		star    = fetch_s1 ? star_rd_q : star_q;
		pix_bit = flip ? sh[7] : sh[0];
		sh_next = flip ? {sh[6:0], 1'b0} : {1'b0, sh[7:1]};
		color   = pix_bit ? fore : (star_hit_s1 ? star : 3'd0);
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			pixel_color_q <= color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			shifter_q   <= 8'd0;
			fore_q      <= 3'd0;
			star_q      <= 3'd0;
		end else if (adv) begin
			// write items end here; only pixels reach the output
			valid_s1    <= q_valid && q_entry.mode == MODE_PIXEL;
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				shifter_q <= sh_next;
				fore_q    <= fore;
				star_q    <= star;
			end
		end
	end

	`ASSERT_CLK(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(vid_rd_q)),
		"stalled pixel lost its fetched data")
	`ASSERT_CLK(a_pop_room, q_pop |-> (!out_valid_q || out_ready),
		"queue popped while output blocked")

endmodule

// ===== dv/scanout_checker.sv =====
// Checker for the bitmap scanout block: watches the channels, predicts and compares pixels
module scanout_checker import bvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [12:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_count,
	input  logic        end_of_frame,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  pixel_color,
	output int          fail_count,
	output int          pending
);

	logic [7:0] vram [VIDEO_WORDS];
	logic [2:0] fg_colours [TABLE_WORDS];
	logic [2:0] star_colours [TABLE_WORDS];
	logic [7:0] shifter;
	logic [2:0] fg_hold;
	logic [2:0] star_hold;
	logic [3:0] blink;
	logic       flipped;
	logic [2:0] colour_q [$];

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		fail_count++;
	endtask

	// model one accepted item; pixels push their expected colour
	task automatic predict_item();
		logic [12:0] vid_a;
		logic [10:0] col_a;
		logic [10:0] star_a;
		logic        lit;
		logic [2:0]  shade;
		case (mode)
			MODE_VIDEO: vram[address] = data;
			MODE_COLOR: fg_colours[address[10:0]] = data[2:0];
			MODE_STAR:  star_colours[address[10:0]] = data[2:0];
			default: begin
				if (x_pos[2:0] == 3'd0) begin
					vid_a = {y_count, x_pos[7:3]};
					if (flipped)
						vid_a = ~vid_a + FLIP_OFFSET;
					col_a   = {flipped, y_count[7:3], x_pos[7:3]};
					star_a  = {blink[3], y_count[7:4], 1'b1, x_pos[7:3]};
					shifter = vram[vid_a];
					fg_hold = fg_colours[col_a];
					star_hold = star_colours[star_a];
				end
				if (flipped) begin
					lit     = shifter[7];
					shifter = shifter << 1;
				end else begin
					lit     = shifter[0];
					shifter = shifter >> 1;
				end
				if (lit)
					shade = fg_hold;
				else if (x_pos[3:0] == 4'hf && y_count[3:0] == 4'hf)
					shade = star_hold;
				else
					shade = 3'd0;
				colour_q.push_back(shade);
				if (end_of_frame)
					blink = blink + 4'd1;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [2:0] want;
		if (!arst_n) begin
			shifter   = '0;
			fg_hold   = '0;
			star_hold = '0;
			blink     = '0;
			flipped   = 1'b0;
			colour_q.delete();
			pending   = 0;
		end else begin
			// output side first: a pixel can never leave on its own transfer edge
			if (out_valid && out_ready) begin
				if (colour_q.size() == 0) begin
					report_mismatch($sformatf("pixel %0d with nothing expected", pixel_color));
				end else begin
					want = colour_q.pop_front();
					if (pixel_color !== want)
						report_mismatch($sformatf("pixel_color got %0d want %0d",
							pixel_color, want));
				end
			end
			if (cfg_we)
				flipped = cfg_wdata;
			if (in_valid && in_ready)
				predict_item();
			pending = colour_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the bitmap scanout block: stimulus, flip settings, idling and verdict
module tb;
	import bvs_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	mode_t       mode = MODE_PIXEL;
	logic [12:0] address = '0;
	logic [7:0]  data = '0;
	logic [7:0]  x_pos = '0;
	logic [7:0]  y_count = '0;
	logic        end_of_frame = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  pixel_color;

	int fail_count;
	int pending;
	int items_sent = 0;
	int send_gap = 0;
	int stall_pct = 0;
	bit hold_start = 1'b0;

	// which store entries have been loaded, so that no fetch reads an unwritten one
	bit vid_written [VIDEO_WORDS];
	bit col_written [TABLE_WORDS];
	bit star_written [TABLE_WORDS];
	logic       flip_now = 1'b0;
	logic [3:0] blink_now = '0;

	bitmap_video_scanout_with_stars u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.address      (address),
		.data         (data),
		.x_pos        (x_pos),
		.y_count      (y_count),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color)
	);

	scanout_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.address      (address),
		.data         (data),
		.x_pos        (x_pos),
		.y_count      (y_count),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("FAIL bitmap_video_scanout_with_stars");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request to fill the queue
	initial begin
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(input mode_t m, input logic [12:0] a, input logic [7:0] d,
			input logic [7:0] x, input logic [7:0] y, input logic eof);
		while ($urandom_range(99) < send_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		address      <= a;
		data         <= d;
		x_pos        <= x;
		y_count      <= y;
		end_of_frame <= eof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (m == MODE_PIXEL && eof)
			blink_now = blink_now + 4'd1;
	endtask

	task automatic write_entry(input mode_t m, input logic [12:0] a, input logic [7:0] d);
		case (m)
			MODE_VIDEO: vid_written[a] = 1'b1;
			MODE_COLOR: col_written[a[10:0]] = 1'b1;
			default:    star_written[a[10:0]] = 1'b1;
		endcase
		send_item(m, a, d, 8'($urandom), 8'($urandom), $urandom_range(7) == 0);
	endtask

	// a pixel; at a fetch position any unloaded entry it reads is written first
	task automatic pixel(input logic [7:0] x, input logic [7:0] y, input logic eof);
		logic [12:0] va;
		logic [10:0] ca;
		logic [10:0] sa;
		if (x[2:0] == 3'd0) begin
			va = {y, x[7:3]};
			if (flip_now)
				va = ~va + FLIP_OFFSET;
			ca = {flip_now, y[7:3], x[7:3]};
			sa = {blink_now[3], y[7:4], 1'b1, x[7:3]};
			if (!vid_written[va])
				write_entry(MODE_VIDEO, va, 8'($urandom));
			if (!col_written[ca])
				write_entry(MODE_COLOR, {2'($urandom_range(3)), ca}, 8'($urandom));
			if (!star_written[sa])
				write_entry(MODE_STAR, {2'($urandom_range(3)), sa}, 8'($urandom));
		end
		send_item(MODE_PIXEL, 13'($urandom), 8'($urandom), x, y, eof);
	endtask

	// drain, let trailing writes settle, then write the flip register
	task automatic set_flip(input logic v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		flip_now = v;
	endtask

	task automatic scan_run();
		logic [7:0] y;
		logic [7:0] x0;
		int         len;
		y = 8'($urandom);
		if ($urandom_range(2) == 0)
			y[3:0] = 4'hf;
		x0  = {5'($urandom), 3'd0};
		len = $urandom_range(24, 8);
		for (int i = 0; i < len; i++)
			pixel(x0 + 8'(i), y, (i == len - 1) && ($urandom_range(2) == 0));
	endtask

	initial begin
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty shifter, store extremes, ignored end of frame, star corner
		set_flip(1'b0);
		pixel(8'h01, 8'h00, 1'b0);
		write_entry(MODE_VIDEO, 13'h1fff, 8'hff);
		write_entry(MODE_VIDEO, 13'h0000, 8'h00);
		write_entry(MODE_COLOR, 13'h1fff, 8'hff);
		write_entry(MODE_STAR, 13'h1800, 8'hf8);
		send_item(MODE_COLOR, 13'h0000, 8'h07, 8'hff, 8'hff, 1'b1);
		pixel(8'h00, 8'h00, 1'b0);
		pixel(8'hff, 8'hff, 1'b0);
		for (int i = 0; i < 8; i++)
			pixel(8'hf8 + 8'(i), 8'hff, i == 7);
		for (int i = 0; i < 8; i++)
			pixel(8'hff, 8'h0f, 1'b1);
		pixel(8'hf0, 8'hff, 1'b0);

		for (int p = 0; p < 8; p++) begin
			set_flip(p[0]);
			case (p / 2)
				0: begin send_gap = 0;  stall_pct = 0;  end
				1: begin send_gap = 77; stall_pct = 0;  end
				2: begin send_gap = 0;  stall_pct = 77; end
				default: begin send_gap = 13; stall_pct = 13; end
			endcase
			if (p == 0 || p == 5)
				hold_start = 1'b1;
			while (items_sent < 25 + 160 * (p + 1)) begin
				pick = $urandom_range(99);
				if (pick < 55)
					scan_run();
				else if (pick < 70)
					repeat ($urandom_range(4, 1))
						write_entry(MODE_VIDEO, 13'($urandom), 8'($urandom));
				else if (pick < 80)
					write_entry($urandom_range(1) ? MODE_COLOR : MODE_STAR,
						13'($urandom), 8'($urandom));
				else if (pick < 95)
					pixel(8'($urandom), 8'($urandom), $urandom_range(7) == 0);
				else
					send_item(MODE_VIDEO, 13'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 1'b1);
			end
		end
		set_flip(1'b0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS bitmap_video_scanout_with_stars");
		else
			$display("FAIL bitmap_video_scanout_with_stars");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bvs_pkg.sv
rtl/bvs_front.sv
rtl/bvs_queue.sv
rtl/bvs_back.sv
rtl/bitmap_video_scanout_with_stars.sv
dv/scanout_checker.sv
dv/tb.sv
